// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, codes, queue entry type.
// Used by the front, queue, back and top modules and the testbench; no dependencies.
`default_nettype none
package rau_pkg;

  // Operand width taken from each input field
  localparam int OPW     = 32;
  localparam int FIELD_W = 32;
  localparam int RW      = 64;
  localparam int CNT_W   = $clog2(RW);

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // One classified item between front and back
  typedef struct packed {
    action_t          act;
    status_t          st;
    logic             a_neg;
    logic [OPW-1:0]   a_n;
    logic [OPW-1:0]   a_d;
    logic             b_neg;
    logic [OPW-1:0]   b_n;
    logic [OPW-1:0]   b_d;
  } entry_t;

  // Magnitude of the low OPW bits, sign-extended
  function automatic logic [OPW-1:0] mag_f(input logic [FIELD_W-1:0] raw);
    logic [OPW-1:0] v;
    v = raw[OPW-1:0];
    return v[OPW-1] ? (~v + {{(OPW-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage
`default_nettype wire

// ===== src/rau_front.sv =====
// Front end: accepts input beats, takes operand magnitudes and signs,
// classifies error cases. Depends on rau_pkg.
`default_nettype none
module rau_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [4*rau_pkg::FIELD_W-1:0] in_tdata,
  input  wire logic [1:0]                    in_tuser,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output rau_pkg::entry_t                    push_entry
);
  import rau_pkg::*;

  logic   fr_valid_r;
  entry_t fr_entry_r;
  entry_t ent_nxt;
  logic [FIELD_W-1:0] an_raw, ad_raw, bn_raw, bd_raw;

  assign an_raw = in_tdata[FIELD_W-1:0];
  assign ad_raw = in_tdata[2*FIELD_W-1:FIELD_W];
  assign bn_raw = in_tdata[3*FIELD_W-1:2*FIELD_W];
  assign bd_raw = in_tdata[4*FIELD_W-1:3*FIELD_W];

  // classify the incoming beat
  always_comb begin
    ent_nxt.act   = action_t'(in_tuser);
    ent_nxt.a_n   = mag_f(an_raw);
    ent_nxt.a_d   = mag_f(ad_raw);
    ent_nxt.b_n   = mag_f(bn_raw);
    ent_nxt.b_d   = mag_f(bd_raw);
    ent_nxt.a_neg = an_raw[OPW-1] ^ ad_raw[OPW-1];
    ent_nxt.b_neg = bn_raw[OPW-1] ^ bd_raw[OPW-1];
    if (ent_nxt.a_d == '0 || ent_nxt.b_d == '0) begin
      ent_nxt.st = ST_ZERO_DEN;
    end else if (ent_nxt.act == ACT_DIV && ent_nxt.b_n == '0) begin
      ent_nxt.st = ST_DIV_ZERO;
    end else begin
      ent_nxt.st = ST_OK;
    end
  end

  assign in_tready  = !fr_valid_r || push_ready;
  assign push_valid = fr_valid_r;
  assign push_entry = fr_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      fr_valid_r <= 1'b1;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fr_entry_r <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rau_queue.sv =====
// Two-entry queue between front and back end.
// Depends on rau_pkg for the entry type.
`default_nettype none
module rau_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire rau_pkg::entry_t wr_entry,
  output logic                 rd_valid,
  input  wire logic            rd_pop,
  output rau_pkg::entry_t      rd_entry
);
  import rau_pkg::*;

  entry_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_entry = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ===== src/rau_back.sv =====
// Back end: sequencer with binary gcd, restoring divider and one multiplier;
// reduces both operands, combines them, reduces the result. Depends on rau_pkg.
`default_nettype none
module rau_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire rau_pkg::entry_t q_entry,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [127:0]         out_tdata,
  output logic [2:0]           out_tuser
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GCD_INIT, S_GCD, S_DIV_N, S_DIV_D,
    S_MUL0, S_MUL1, S_MUL2, S_COMB, S_OUT
  } bstate_t;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;

  bstate_t state_r, state_nxt;
  phase_t  phase_r;

  action_t        act_r;
  status_t        st_r;
  logic           aneg_r, bneg_r, rneg_r, red_r;
  logic [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic [RW-1:0]  rn_r, rd_r, t1_r, t2_r;
  logic [RW-1:0]  x_r, y_r, g_r, q_r, rem_r;
  logic [CNT_W-1:0] k_r, cnt_r;

  logic            out_valid_r;
  logic [RW-1:0]   onum_r;
  logic [RW-2:0]   oden_r;
  logic            ored_r;
  status_t         ost_r;

  logic [RW-1:0]   num_sel, den_sel, gval;
  logic            gdone, div_last, out_load;
  logic [RW:0]     rem_sh;
  logic            ge;
  logic [RW-1:0]   rem_new, q_new;
  logic [OPW-1:0]  mul_x, mul_y;
  logic [2*OPW-1:0] prod;
  bstate_t         after_red;

  // operand pair for the current reduction
  always_comb begin
    case (phase_r)
      PH_A: begin
        num_sel = RW'(an_r);
        den_sel = RW'(ad_r);
      end
      PH_B: begin
        num_sel = RW'(bn_r);
        den_sel = RW'(bd_r);
      end
      default: begin
        num_sel = rn_r;
        den_sel = rd_r;
      end
    endcase
  end

  // gcd and divider step logic
  assign gdone    = (x_r == '0) || (y_r == '0);
  assign gval     = (x_r | y_r) << k_r;
  assign rem_sh   = {rem_r, q_r[RW-1]};
  assign ge       = rem_sh >= {1'b0, g_r};
  assign rem_new  = ge ? RW'(rem_sh - {1'b0, g_r}) : rem_sh[RW-1:0];
  assign q_new    = {q_r[RW-2:0], ge};
  assign div_last = cnt_r == CNT_W'(RW-1);

  // shared multiplier
  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_x = an_r;
        mul_y = (act_r == ACT_MUL) ? bn_r : bd_r;
      end
      S_MUL1: begin
        mul_x = bn_r;
        mul_y = ad_r;
      end
      default: begin
        mul_x = ad_r;
        mul_y = (act_r == ACT_DIV) ? bn_r : bd_r;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  always_comb begin
    unique case (phase_r)
      PH_A:    after_red = S_GCD_INIT;
      PH_B:    after_red = S_MUL0;
      default: after_red = S_OUT;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = (q_entry.st == ST_OK) ? S_GCD_INIT : S_OUT;
      end
      S_GCD_INIT: state_nxt = S_GCD;
      S_GCD: begin
        if (gdone) state_nxt = (gval == RW'(1)) ? after_red : S_DIV_N;
      end
      S_DIV_N: if (div_last) state_nxt = S_DIV_D;
      S_DIV_D: if (div_last) state_nxt = after_red;
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_COMB;
      S_COMB:  state_nxt = S_GCD_INIT;
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE:  q_pop    = q_valid;
      S_OUT:   out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        act_r   <= q_entry.act;
        st_r    <= q_entry.st;
        aneg_r  <= q_entry.a_neg;
        an_r    <= q_entry.a_n;
        ad_r    <= q_entry.a_d;
        bneg_r  <= q_entry.b_neg;
        bn_r    <= q_entry.b_n;
        bd_r    <= q_entry.b_d;
        phase_r <= PH_A;
      end
      S_GCD_INIT: begin
        x_r <= num_sel;
        y_r <= den_sel;
        k_r <= '0;
        // a zero numerator carries no sign
        if (num_sel == '0) begin
          case (phase_r)
            PH_A:    aneg_r <= 1'b0;
            PH_B:    bneg_r <= 1'b0;
            default: rneg_r <= 1'b0;
          endcase
        end
      end
      S_GCD: begin
        if (gdone) begin
          g_r   <= gval;
          red_r <= gval > RW'(1);
          q_r   <= num_sel;
          rem_r <= '0;
          cnt_r <= '0;
          if (gval == RW'(1)) begin
            if (phase_r == PH_A) phase_r <= PH_B;
          end
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      S_DIV_N, S_DIV_D: begin
        q_r   <= q_new;
        rem_r <= rem_new;
        cnt_r <= cnt_r + 1'b1;
        if (div_last) begin
          q_r   <= den_sel;
          rem_r <= '0;
          if (state_r == S_DIV_N) begin
            case (phase_r)
              PH_A:    an_r <= q_new[OPW-1:0];
              PH_B:    bn_r <= q_new[OPW-1:0];
              default: rn_r <= q_new;
            endcase
          end else begin
            case (phase_r)
              PH_A: begin
                ad_r    <= q_new[OPW-1:0];
                phase_r <= PH_B;
              end
              PH_B:    bd_r <= q_new[OPW-1:0];
              default: rd_r <= q_new;
            endcase
          end
        end
      end
      S_MUL0: t1_r <= RW'(prod);
      S_MUL1: t2_r <= RW'(prod);
      S_MUL2: rd_r <= RW'(prod);
      S_COMB: begin
        phase_r <= PH_R;
        if (act_r == ACT_MUL || act_r == ACT_DIV) begin
          rn_r   <= t1_r;
          rneg_r <= aneg_r ^ bneg_r;
        end else if (aneg_r == (bneg_r ^ (act_r == ACT_SUB))) begin
          rn_r   <= t1_r + t2_r;
          rneg_r <= aneg_r;
        end else if (t1_r >= t2_r) begin
          rn_r   <= t1_r - t2_r;
          rneg_r <= aneg_r;
        end else begin
          rn_r   <= t2_r - t1_r;
          rneg_r <= bneg_r ^ (act_r == ACT_SUB);
        end
      end
      S_OUT: begin
        if (out_load) begin
          ost_r <= st_r;
          if (st_r == ST_OK) begin
            onum_r <= rneg_r ? (~rn_r + RW'(1)) : rn_r;
            oden_r <= rd_r[RW-2:0];
            ored_r <= red_r;
          end else begin
            onum_r <= '0;
            oden_r <= '0;
            ored_r <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, oden_r, onum_r};
  assign out_tuser  = {ost_r, ored_r};

endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one item in, one reduced fraction out.
// Each ok item runs three reductions in turn (operand a, operand b, result),
// each an init step and a binary gcd, plus a numerator and a denominator
// divide when gcd > 1; the multiply and combine steps run before the third.
// Error items go straight to the output. One item in the back end
// at a time; front stage and 2-entry queue hold more.
// Reset: synchronous active-low rst_n clears all control and valid state.
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  wire logic [1:0]   in_tuser,   // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // res_num[63:0], res_den[126:64], pad
  output logic [2:0]        out_tuser   // was_reduced, status[2:1]
);
  import rau_pkg::*;

  logic   f_valid, f_ready, q_valid, q_pop;
  entry_t f_entry, q_entry;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .push_valid(f_valid), .push_ready(f_ready), .push_entry(f_entry)
  );

  rau_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_entry(f_entry),
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_entry(q_entry)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top.
// Depends only on the top-level ports.
`default_nettype none
module rau_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [2:0]   out_tuser
);

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // error beats carry zero result fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] != 2'd0 |-> out_tdata == '0 && !out_tuser[0])
    else $error("error beat with nonzero result");

  // ok beats have a nonzero denominator, status never reserved
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'd3 &&
      (out_tuser[2:1] != 2'd0 || out_tdata[126:64] != '0))
    else $error("bad status or zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

// ===== sim/tb_rational_arithmetic_unit.sv =====
// Testbench for rational_arithmetic_unit: directed table then random beats, each result
// checked against a typed-in expectation or a behavioral fraction predictor. Needs rau_pkg.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  typedef struct {
    action_t     act;
    logic [31:0] an, ad, bn, bd;
  } operands_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic        red;
    status_t     st;
  } fraction_t;

  // Directed row: operands, plus optional typed-in expectation
  typedef struct {
    operands_t ops;
    logic      fixed;
    fraction_t want;
  } row_t;

  localparam logic [31:0] MAXP = 32'h7fffffff;
  localparam logic [31:0] MINN = 32'h80000000;
  localparam logic [31:0] NEG1 = 32'hffffffff;
  localparam int N_RANDOM = 1600;
  localparam longint CYCLE_LIMIT = 8000000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [127:0] in_tdata, out_tdata;
  logic [1:0] in_tuser;
  logic [2:0] out_tuser;

  fraction_t pending_results[$];
  int errors;
  longint cycle_cnt;
  bit sending_done;
  bit hold_off;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sign-extend low OPW bits, return sign and magnitude
  function automatic void split_sign(input logic [31:0] raw, output bit neg,
                                     output logic [63:0] mag);
    logic [63:0] v;
    v = 64'(raw[OPW-1:0]);
    neg = v[OPW-1];
    mag = neg ? ((~v + 64'd1) & ((64'd1 << OPW) - 64'd1)) : v;
  endfunction

  function automatic logic [63:0] euclid(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit lowest_terms(inout bit neg, inout logic [63:0] n,
                                      inout logic [63:0] d);
    logic [63:0] g;
    g = euclid(n, d);
    if (g != 0) begin
      n = n / g;
      d = d / g;
    end
    if (n == 0) neg = 1'b0;
    return g > 1;
  endfunction

  function automatic fraction_t predict_fraction(input operands_t op);
    fraction_t r;
    bit an_s, ad_s, bn_s, bd_s, rn_s, n2, dummy;
    logic [63:0] an, ad, bn, bd, t1, t2, rn, rd;
    r = '{num: '0, den: '0, red: 1'b0, st: ST_OK};
    split_sign(op.an, an_s, an);
    split_sign(op.ad, ad_s, ad);
    split_sign(op.bn, bn_s, bn);
    split_sign(op.bd, bd_s, bd);
    if (ad == 0 || bd == 0) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    an_s = an_s ^ ad_s;
    bn_s = bn_s ^ bd_s;
    dummy = lowest_terms(an_s, an, ad);
    dummy = lowest_terms(bn_s, bn, bd);
    if (op.act == ACT_DIV && bn == 0) begin
      r.st = ST_DIV_ZERO;
      return r;
    end
    case (op.act)
      ACT_ADD, ACT_SUB: begin
        t1 = an * bd;
        t2 = bn * ad;
        n2 = (op.act == ACT_SUB) ? !bn_s : bn_s;
        if (an_s == n2) begin
          rn = t1 + t2; rn_s = an_s;
        end else if (t1 >= t2) begin
          rn = t1 - t2; rn_s = an_s;
        end else begin
          rn = t2 - t1; rn_s = n2;
        end
        rd = ad * bd;
      end
      ACT_MUL: begin
        rn = an * bn; rd = ad * bd; rn_s = an_s ^ bn_s;
      end
      default: begin
        rn = an * bd; rd = ad * bn; rn_s = an_s ^ bn_s;
      end
    endcase
    r.red = lowest_terms(rn_s, rn, rd);
    r.num = rn_s ? (64'd0 - rn) : rn;
    r.den = rd[62:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 20)) - 32'd10;
      1: return $urandom_range(0, 1) ? MAXP : MINN;
      2: return 32'($urandom_range(1, 5000)) * 32'($urandom_range(1, 5000));
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  // Bias toward shared factors so reduction actually happens
  function automatic operands_t rand_ops();
    operands_t o;
    logic [31:0] k;
    o.act = action_t'($urandom_range(0, 3));
    o.an = rand_operand();
    o.ad = rand_operand();
    o.bn = rand_operand();
    o.bd = rand_operand();
    if ($urandom_range(0, 2) == 0) begin
      k = 32'($urandom_range(1, 60));
      o.an = 32'($signed(o.an) % 30000) * k;
      o.ad = 32'($signed(o.ad) % 30000) * k;
    end
    // keep zero denominators occasional
    if (o.ad == 0 && $urandom_range(0, 3) != 0) o.ad = 32'd1;
    if (o.bd == 0 && $urandom_range(0, 3) != 0) o.bd = NEG1;
    return o;
  endfunction

  task automatic send_beat(input operands_t op);
    repeat ($urandom_range(0, 12)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {op.bd, op.bn, op.ad, op.an};
    in_tuser  <= op.act;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stimulus
  initial begin
    row_t dir_rows[$];
    operands_t op;
    fraction_t z;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_ADD;
    errors = 0;
    sending_done = 1'b0;
    z = '{num: '0, den: '0, red: 1'b0, st: ST_ZERO_DEN};
    dir_rows = '{
      '{'{ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b1, z},
      '{'{ACT_DIV, 32'd1, 32'd1, 32'd0, 32'd0}, 1'b1, z},
      '{'{ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd7}, 1'b1,
        '{64'd0, 63'd0, 1'b0, ST_DIV_ZERO}},
      '{'{ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd2}, 1'b1,
        '{64'd1, 63'd1, 1'b1, ST_OK}},
      '{'{ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd2}, 1'b1,
        '{64'd0, 63'd1, 1'b1, ST_OK}},
      '{'{ACT_MUL, 32'd2, 32'd3, 32'd3, 32'd2}, 1'b1,
        '{64'd1, 63'd1, 1'b1, ST_OK}},
      '{'{ACT_DIV, 32'd1, 32'd3, NEG1, 32'd3}, 1'b1,
        '{64'hffffffffffffffff, 63'd1, 1'b1, ST_OK}},
      '{'{ACT_MUL, 32'd0, 32'd5, 32'd7, 32'd9}, 1'b1,
        '{64'd0, 63'd1, 1'b1, ST_OK}},
      '{'{ACT_ADD, MINN, 32'd1, MINN, 32'd1}, 1'b0, z},
      '{'{ACT_SUB, MINN, NEG1, MAXP, 32'd1}, 1'b0, z},
      '{'{ACT_MUL, MINN, MAXP, MINN, MAXP}, 1'b0, z},
      '{'{ACT_DIV, MAXP, MINN, MINN, MAXP}, 1'b0, z},
      '{'{ACT_ADD, MAXP, MAXP, MAXP, 32'd1}, 1'b0, z},
      '{'{ACT_MUL, MAXP, 32'd1, MAXP, 32'd1}, 1'b0, z},
      '{'{ACT_DIV, MAXP, 32'd1, 32'd1, MAXP}, 1'b0, z},
      '{'{ACT_ADD, MINN, MAXP, MINN, 32'd1}, 1'b0, z},
      '{'{ACT_SUB, 32'd6, 32'hfffffff7, 32'hfffffffc, 32'd10}, 1'b0, z},
      '{'{ACT_DIV, 32'hfffffff4, 32'd18, 32'hfffffffa, 32'hfffffff1}, 1'b0, z},
      '{'{ACT_MUL, 32'h55555555, 32'haaaaaaab, 32'h12345678, 32'hedcba988},
        1'b0, z}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      pending_results.push_back(dir_rows[i].fixed ? dir_rows[i].want
                                                  : predict_fraction(dir_rows[i].ops));
      send_beat(dir_rows[i].ops);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      op = rand_ops();
      pending_results.push_back(predict_fraction(op));
      send_beat(op);
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Long receiver hold-off early in the random part, so the input backs up
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (8000) @(posedge clk);
    hold_off = 1'b0;
  end

  // Result side: random stalls, check each accepted beat
  initial begin
    fraction_t exp_r, got;
    int gap;
    out_tready = 1'b0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.num = out_tdata[63:0];
        got.den = out_tdata[126:64];
        got.red = out_tuser[0];
        got.st  = status_t'(out_tuser[2:1]);
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: num=%h den=%h", $time,
                   got.num, got.den);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.num !== exp_r.num) begin
            $display("%0t: res_num exp %h got %h", $time, exp_r.num, got.num);
            errors++;
          end
          if (got.den !== exp_r.den) begin
            $display("%0t: res_den exp %h got %h", $time, exp_r.den, got.den);
            errors++;
          end
          if (got.red !== exp_r.red) begin
            $display("%0t: was_reduced exp %b got %b", $time, exp_r.red, got.red);
            errors++;
          end
          if (got.st !== exp_r.st) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.st, got.st);
            errors++;
          end
        end
        gap = $urandom_range(0, 12);
        // stretches with no stall
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End of run and watchdog
  initial begin
    cycle_cnt = 0;
    while (!(sending_done && pending_results.size() == 0) && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
    end else begin
      repeat (1000) @(posedge clk);
      if (errors == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rau_pkg.sv
src/rau_front.sv
src/rau_queue.sv
src/rau_back.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
sim/tb_rational_arithmetic_unit.sv
